[hw/rtl/tli_pkg.sv]
// Shared constants, codes and types of the table linear interpolator.
`timescale 1ns / 1ps
`default_nettype none

package tli_pkg;

	// Default sizes of the breakpoint table and of the value fields.
	localparam int MAX_POINTS_DEF = 64;
	localparam int VALUE_W_DEF    = 32;

	// Fixed field widths of the ports.
	localparam int CNT_W      = 7;
	localparam int IDX_W      = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	// A table needs at least two breakpoints to form a segment.
	localparam int MIN_POINTS = 2;

	// Register reset values.
	localparam logic [CNT_W-1:0] ACTIVE_RST = 7'd2;
	localparam logic             CLAMP_RST  = 1'b0;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP  = 1'd1;

	// Input commands.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Result status codes.
	typedef logic [1:0] status_t;
	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_BADARG = 2'd1;
	localparam status_t ST_NOTINC = 2'd2;
	localparam status_t ST_OVF    = 2'd3;

	// Finished result handed from the sequencer to the output register.
	typedef struct packed {
		logic    valid;
		status_t status;
	} rsp_t;

endpackage

`default_nettype wire

[hw/rtl/table_linear_interpolator_top.sv]
// Operation: a write beat goes straight into the breakpoint memory; a query result passes
// through a scan of the N active breakpoints over the memory read port, the segment reads
// in S_RD0 to S_RD2, the two partial products, 2 * VALUE_WIDTH + 2 divider steps, the done
// flag and the output register, and ends early on an error or a clamped query.
// Throughput: one query at a time; the next beat is taken once the result is in the output
// register. Reset clears the control state and sets active_points to 2 and clamp_enable to
// 0; the breakpoint memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module table_linear_interpolator_top #(
	parameter int MAX_POINTS  = tli_pkg::MAX_POINTS_DEF,
	parameter int VALUE_WIDTH = tli_pkg::VALUE_W_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tli_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tli_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cmd,
	input  logic [tli_pkg::IDX_W-1:0]      point_index,
	input  logic signed [VALUE_WIDTH-1:0]  point_x,
	input  logic signed [VALUE_WIDTH-1:0]  point_y,
	input  logic signed [VALUE_WIDTH-1:0]  query_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [VALUE_WIDTH-1:0]  result_value,
	output logic [1:0]                     status
);

	import tli_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int EW = ((AW > IDX_W) ? AW : IDX_W) + 1;
	localparam int W  = VALUE_WIDTH;

	logic [CNT_W-1:0]    active_q;
	logic                clamp_q;
	logic                busy;
	logic                in_acc;
	logic                wr_ok;
	logic                mem_we;
	logic [AW-1:0]       mem_raddr;
	logic signed [W-1:0] rx;
	logic signed [W-1:0] ry;
	logic                md_start;
	logic [W:0]          a_mag;
	logic [W:0]          dy_mag;
	logic [W:0]          dx;
	logic                md_done;
	logic [2*W+1:0]      quot;
	logic                take;
	rsp_t                rsp;
	logic signed [W-1:0] res_value;
	logic                out_valid_q;
	logic signed [W-1:0] result_q;
	status_t             status_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RST;
			clamp_q  <= CLAMP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE: active_q <= cfg_data[CNT_W-1:0];
				REG_CLAMP:  clamp_q  <= cfg_data[0];
				default:    ;
			endcase
		end
	end

	// Input beats: writes go straight to memory, queries start the sequencer.
	assign in_stall = busy;
	assign in_acc   = in_valid && !busy;
	assign wr_ok    = EW'(point_index) < EW'(MAX_POINTS);
	assign mem_we   = in_acc && (cmd == CMD_WRITE) && wr_ok;

	tli_bp_mem #(
		.DEPTH (MAX_POINTS),
		.WIDTH (W),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (AW'(point_index)),
		.wx    (point_x),
		.wy    (point_y),
		.raddr (mem_raddr),
		.rx    (rx),
		.ry    (ry)
	);

	tli_seq #(
		.MAX_POINTS  (MAX_POINTS),
		.VALUE_WIDTH (W),
		.AW          (AW)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.active_points (active_q),
		.clamp_enable  (clamp_q),
		.start         (in_acc && (cmd == CMD_QUERY)),
		.query_value   (query_value),
		.busy          (busy),
		.mem_raddr     (mem_raddr),
		.rx            (rx),
		.ry            (ry),
		.md_start      (md_start),
		.a_mag         (a_mag),
		.dy_mag        (dy_mag),
		.dx            (dx),
		.md_done       (md_done),
		.quot          (quot),
		.take          (take),
		.rsp           (rsp),
		.res_value     (res_value)
	);

	tli_muldiv #(
		.VALUE_WIDTH (W)
	) u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.a_mag  (a_mag),
		.dy_mag (dy_mag),
		.dx     (dx),
		.done   (md_done),
		.quot   (quot)
	);

	// Output register: takes a new result whenever it is empty or being drained.
	assign take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			result_q    <= '0;
			status_q    <= ST_OK;
		end else if (take) begin
			out_valid_q <= rsp.valid;
			if (rsp.valid) begin
				result_q <= res_value;
				status_q <= rsp.status;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign status       = status_q;

endmodule

`default_nettype wire

[hw/rtl/tli_bp_mem.sv]
// Breakpoint memories: x and y stores, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tli_bp_mem #(
	parameter int DEPTH = tli_pkg::MAX_POINTS_DEF,
	parameter int WIDTH = tli_pkg::VALUE_W_DEF,
	parameter int AW    = $clog2(tli_pkg::MAX_POINTS_DEF)
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic signed [WIDTH-1:0] wx,
	input  logic signed [WIDTH-1:0] wy,
	input  logic [AW-1:0]           raddr,
	output logic signed [WIDTH-1:0] rx,
	output logic signed [WIDTH-1:0] ry
);

	logic [WIDTH-1:0] mem_x [DEPTH];
	logic [WIDTH-1:0] mem_y [DEPTH];

	// Write one breakpoint.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_x[waddr] <= wx;
			mem_y[waddr] <= wy;
		end
	end

	// Read both coordinates of one breakpoint; the data is registered and appears in the next cycle.
	always_ff @(posedge clk) begin
		rx <= signed'(mem_x[raddr]);
		ry <= signed'(mem_y[raddr]);
	end

endmodule

`default_nettype wire

[hw/rtl/tli_muldiv.sv]
// Multiply-divide unit: |a| * |dy| / dx with a split multiplier and a restoring divider.
`timescale 1ns / 1ps
`default_nettype none

module tli_muldiv #(
	parameter int VALUE_WIDTH = tli_pkg::VALUE_W_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [VALUE_WIDTH:0]     a_mag,
	input  logic [VALUE_WIDTH:0]     dy_mag,
	input  logic [VALUE_WIDTH:0]     dx,
	output logic                     done,
	output logic [2*VALUE_WIDTH+1:0] quot
);

	localparam int W   = VALUE_WIDTH;
	localparam int QW  = 2 * W + 2;
	localparam int CH  = (W + 2) / 2;
	localparam int PPW = W + 1 + CH;
	localparam int KW  = $clog2(QW);

	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_MUL1 = 2'd1;
	localparam logic [1:0] M_MUL2 = 2'd2;
	localparam logic [1:0] M_DIV  = 2'd3;

	logic [1:0]     state_q;
	logic [PPW-1:0] pp_q;
	logic [QW-1:0]  dvd_q;
	logic [W:0]     rem_q;
	logic [KW-1:0]  cnt_q;
	logic           done_q;

	logic [W+1:0]   shl;
	logic           ge;
	logic [W+1:0]   rem_n;

	// One restoring division step: shift in the next dividend bit and subtract.
	always_comb begin
		shl   = {rem_q, dvd_q[QW-1]};
		ge    = shl >= {1'b0, dx};
		rem_n = ge ? (shl - {1'b0, dx}) : shl;
	end

	// Two partial products, then one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			pp_q    <= '0;
			dvd_q   <= '0;
			rem_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (start) begin
						pp_q    <= PPW'(a_mag) * PPW'(dy_mag[CH-1:0]);
						state_q <= M_MUL1;
					end
				end
				M_MUL1: begin
					dvd_q   <= QW'(pp_q);
					pp_q    <= PPW'(a_mag) * PPW'(dy_mag[W:CH]);
					state_q <= M_MUL2;
				end
				M_MUL2: begin
					dvd_q   <= dvd_q + (QW'(pp_q) << CH);
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= M_DIV;
				end
				M_DIV: begin
					rem_q <= rem_n[W:0];
					dvd_q <= {dvd_q[QW-2:0], ge};
					cnt_q <= cnt_q + KW'(1);
					if (cnt_q == KW'(QW - 1)) begin
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign quot = dvd_q;

endmodule

`default_nettype wire

[hw/rtl/tli_seq.sv]
// Query sequencer: table scan, segment reads, operand setup and result saturation.
`timescale 1ns / 1ps
`default_nettype none

module tli_seq #(
	parameter int MAX_POINTS  = tli_pkg::MAX_POINTS_DEF,
	parameter int VALUE_WIDTH = tli_pkg::VALUE_W_DEF,
	parameter int AW          = $clog2(tli_pkg::MAX_POINTS_DEF)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tli_pkg::CNT_W-1:0]     active_points,
	input  logic                          clamp_enable,
	input  logic                          start,
	input  logic signed [VALUE_WIDTH-1:0] query_value,
	output logic                          busy,
	output logic [AW-1:0]                 mem_raddr,
	input  logic signed [VALUE_WIDTH-1:0] rx,
	input  logic signed [VALUE_WIDTH-1:0] ry,
	output logic                          md_start,
	output logic [VALUE_WIDTH:0]          a_mag,
	output logic [VALUE_WIDTH:0]          dy_mag,
	output logic [VALUE_WIDTH:0]          dx,
	input  logic                          md_done,
	input  logic [2*VALUE_WIDTH+1:0]      quot,
	input  logic                          take,
	output tli_pkg::rsp_t                 rsp,
	output logic signed [VALUE_WIDTH-1:0] res_value
);

	import tli_pkg::*;

	localparam int W  = VALUE_WIDTH;
	localparam int QW = 2 * W + 2;
	localparam int CW = AW + 1;
	localparam int NW = (CNT_W > CW) ? CNT_W : CW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_RD0  = 3'd2;
	localparam logic [2:0] S_RD1  = 3'd3;
	localparam logic [2:0] S_RD2  = 3'd4;
	localparam logic [2:0] S_MUL  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	logic [2:0]            state_q;
	logic signed [W-1:0]   q_q;
	logic signed [W-1:0]   prev_q;
	logic signed [W-1:0]   x0s_q;
	logic signed [W-1:0]   y0s_q;
	logic [CW-1:0]         rd_i_q;
	logic                  chk_v_s1;
	logic [AW-1:0]         chk_i_s1;
	logic                  bad_q;
	logic                  found_q;
	logic                  le_x0_q;
	logic                  ge_last_q;
	logic [AW-1:0]         seg_q;
	logic                  neg_q;
	logic                  md_start_q;
	logic [W:0]            a_mag_q;
	logic [W:0]            dy_mag_q;
	logic [W:0]            dx_q;
	status_t               st_q;
	logic signed [W-1:0]   val_q;

	logic [NW-1:0]         n_w;
	logic                  n_bad;
	logic [CW-1:0]         n_c;
	logic [AW-1:0]         last_i;
	logic [AW-1:0]         seg_sel;
	logic signed [W:0]     a_d;
	logic signed [W:0]     dx_d;
	logic signed [W:0]     dy_d;
	logic signed [W+2:0]   y0_e;
	logic signed [W+2:0]   q_e;
	logic signed [W+2:0]   sum_d;
	logic                  sat_d;
	logic                  ovf_d;
	logic signed [W-1:0]   fin_d;
	status_t               fin_st_d;

	// Point count checks and the segment that the scan selected.
	always_comb begin
		n_w     = NW'(active_points);
		n_bad   = (n_w < NW'(MIN_POINTS)) || (n_w > NW'(MAX_POINTS));
		n_c     = CW'(n_w);
		last_i  = AW'(n_c - CW'(1));
		seg_sel = found_q ? seg_q : AW'(last_i - AW'(1));
	end

	// Read address: the scan index, then the two ends of the segment.
	always_comb begin
		case (state_q)
			S_SCAN:  mem_raddr = rd_i_q[AW-1:0];
			S_RD1:   mem_raddr = seg_sel + AW'(1);
			default: mem_raddr = seg_sel;
		endcase
	end

	// Segment differences; the upper point arrives on the read port in S_RD2.
	always_comb begin
		a_d  = (W+1)'(q_q) - (W+1)'(x0s_q);
		dx_d = (W+1)'(rx) - (W+1)'(x0s_q);
		dy_d = (W+1)'(ry) - (W+1)'(y0s_q);
	end

	// Add the signed quotient to y0 and saturate to the value range.
	always_comb begin
		y0_e  = (W+3)'(y0s_q);
		q_e   = signed'({2'b00, quot[W:0]});
		sum_d = neg_q ? (y0_e - q_e) : (y0_e + q_e);
		sat_d = |quot[QW-1:W+1];
		ovf_d = sum_d[W+2:W-1] != {4{sum_d[W-1]}};
		if (sat_d) begin
			fin_d    = neg_q ? VMIN : VMAX;
			fin_st_d = ST_OVF;
		end else if (ovf_d) begin
			fin_d    = sum_d[W+2] ? VMIN : VMAX;
			fin_st_d = ST_OVF;
		end else begin
			fin_d    = sum_d[W-1:0];
			fin_st_d = ST_OK;
		end
	end

	// Query sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rd_i_q     <= '0;
			chk_v_s1   <= 1'b0;
			chk_i_s1   <= '0;
			bad_q      <= 1'b0;
			found_q    <= 1'b0;
			le_x0_q    <= 1'b0;
			ge_last_q  <= 1'b0;
			seg_q      <= '0;
			md_start_q <= 1'b0;
			neg_q      <= 1'b0;
			a_mag_q    <= '0;
			dy_mag_q   <= '0;
			dx_q       <= '0;
			q_q        <= '0;
			prev_q     <= '0;
			x0s_q      <= '0;
			y0s_q      <= '0;
			st_q       <= ST_OK;
			val_q      <= '0;
		end else begin
			md_start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						q_q      <= query_value;
						rd_i_q   <= '0;
						chk_v_s1 <= 1'b0;
						bad_q    <= 1'b0;
						found_q  <= 1'b0;
						if (n_bad) begin
							st_q    <= ST_BADARG;
							val_q   <= '0;
							state_q <= S_FIN;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				// One breakpoint x per cycle: order check, segment search, end tests.
				S_SCAN: begin
					chk_v_s1 <= rd_i_q < n_c;
					chk_i_s1 <= rd_i_q[AW-1:0];
					if (rd_i_q < n_c) begin
						rd_i_q <= rd_i_q + CW'(1);
					end
					if (chk_v_s1) begin
						prev_q <= rx;
						if (chk_i_s1 == '0) begin
							le_x0_q <= q_q <= rx;
						end else begin
							if (rx <= prev_q) begin
								bad_q <= 1'b1;
							end
							if (!found_q && (q_q <= rx)) begin
								found_q <= 1'b1;
								seg_q   <= chk_i_s1 - AW'(1);
							end
						end
						if (chk_i_s1 == last_i) begin
							ge_last_q <= q_q >= rx;
							state_q   <= S_RD0;
						end
					end
				end
				S_RD0: begin
					state_q <= S_RD1;
				end
				S_RD1: begin
					x0s_q   <= rx;
					y0s_q   <= ry;
					state_q <= S_RD2;
				end
				// Early results, or operands for the multiply-divide unit.
				S_RD2: begin
					if (bad_q) begin
						st_q    <= ST_NOTINC;
						val_q   <= '0;
						state_q <= S_FIN;
					end else if (clamp_enable && le_x0_q) begin
						st_q    <= ST_OK;
						val_q   <= y0s_q;
						state_q <= S_FIN;
					end else if (clamp_enable && ge_last_q) begin
						st_q    <= ST_OK;
						val_q   <= ry;
						state_q <= S_FIN;
					end else begin
						a_mag_q    <= a_d[W] ? unsigned'(-a_d) : unsigned'(a_d);
						dy_mag_q   <= dy_d[W] ? unsigned'(-dy_d) : unsigned'(dy_d);
						dx_q       <= unsigned'(dx_d);
						neg_q      <= a_d[W] ^ dy_d[W];
						md_start_q <= 1'b1;
						state_q    <= S_MUL;
					end
				end
				S_MUL: begin
					if (md_done) begin
						st_q    <= fin_st_d;
						val_q   <= fin_d;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = state_q != S_IDLE;
	assign md_start   = md_start_q;
	assign a_mag      = a_mag_q;
	assign dy_mag     = dy_mag_q;
	assign dx         = dx_q;
	assign rsp.valid  = state_q == S_FIN;
	assign rsp.status = st_q;
	assign res_value  = val_q;

endmodule

`default_nettype wire

[hw/rtl/tli_checker.sv]
// Port-level checker of the table linear interpolator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tli_checker #(
	parameter int VALUE_WIDTH = tli_pkg::VALUE_W_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic [tli_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [tli_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           cmd,
	input logic [tli_pkg::IDX_W-1:0]      point_index,
	input logic signed [VALUE_WIDTH-1:0]  point_x,
	input logic signed [VALUE_WIDTH-1:0]  point_y,
	input logic signed [VALUE_WIDTH-1:0]  query_value,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic signed [VALUE_WIDTH-1:0]  result_value,
	input logic [1:0]                     status
);

	import tli_pkg::*;

	localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	// A result beat that is held back stays valid and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(status))
		else $error("result beat changed while stalled");

	// Error results carry a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_BADARG || status == ST_NOTINC) |-> result_value == '0)
		else $error("error result with nonzero value");

	// An overflow result sits on one of the range bounds.
	a_ovf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OVF |-> result_value == VMAX || result_value == VMIN)
		else $error("overflow result not saturated");

	// A query beat makes the block busy in the next cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_QUERY |=> in_stall)
		else $error("input not stalled after a query beat");

endmodule

bind table_linear_interpolator_top tli_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_tli_checker (.*);

`default_nettype wire
